### design/poi_pkg.sv
`timescale 1ns / 1ps
package poi_pkg;

  localparam int POS_WIDTH_DEF    = 48;
  localparam int ANGLE_WIDTH_DEF  = 32;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] YAW_SCALE   = 32'd2935890503;

  localparam logic OP_INTEGRATE = 1'b0;
  localparam logic OP_RESET     = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw_rate;
    logic [15:0] step_us;
  } in_item_t;

  typedef struct packed {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic        updated;
  } out_item_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        5'd28: r = 32'd3;
        5'd29: r = 32'd1;
        5'd30: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### design/poi_stream_if.sv
`timescale 1ns / 1ps
interface poi_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/poi_serial_mul.sv
`timescale 1ns / 1ps
module poi_serial_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [AW-1:0]         a,
  input  logic [BW-1:0]         b,
  output logic                  done,
  output logic [AW+BW-1:0]      prod
);
  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc;
  logic [BW-1:0]    mult;
  logic [AW+BW-1:0] mcand;
  logic [CW-1:0]    count;
  logic             busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      acc   <= '0;
      mult  <= b;
      mcand <= {{BW{1'b0}}, a};
      count <= CW'(BW);
    end else if (busy) begin
      if (mult[0]) begin
        acc <= acc + mcand;
      end
      mult  <= mult >> 1;
      mcand <= mcand << 1;
      count <= count - 1'b1;
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### design/planar_odometry_integrator_top.sv
`timescale 1ns / 1ps
// Dead-reckoning pose integrator. One transaction at a time. An integrate
// transaction with nonzero step keeps the input busy after acceptance while
// the CORDIC iterates one rotation a cycle, then one shift-add multiplier works
// bit-serially through eight products (velocity by cosine and sine, then the
// rotated velocity by step, then yaw by step and scale), and then saturation,
// pose update, result load and return to idle follow in turn. Reset or zero
// step transactions keep the input busy through result load and return to idle.
// A result still waiting at the output holds the next one back until it is taken.
module planar_odometry_integrator_top #(
  parameter int POS_WIDTH    = poi_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = poi_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
  input logic clk,
  input logic rst,
  poi_stream_if.sink   in_ch,
  poi_stream_if.source out_ch
);
  localparam int SW = $clog2(CORDIC_STEPS + 1);
  localparam int PW = POS_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CORD  = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_WAIT  = 8'b00001000,
    S_POS   = 8'b00010000,
    S_YAW   = 8'b00100000,
    S_DONE  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state;
  poi_pkg::in_item_t item;

  logic [PW-1:0]          x_pos, y_pos;
  logic [ANGLE_WIDTH-1:0] heading_angle;
  logic                   changed;

  logic signed [33:0] cx, cy;
  logic signed [33:0] cz;
  logic [SW-1:0]      step;
  logic [1:0]         quad;
  logic signed [33:0] cosv, sinv;

  // multiply sequencing
  logic [2:0]  mstep;
  logic        mstart, mdone;
  logic [47:0] ma;
  logic [32:0] mb;
  logic [80:0] mprod;
  logic signed [63:0] t_xc, t_ys, t_xs;
  logic signed [63:0] dxp, dyp;
  logic [80:0] yaw_mag;

  poi_serial_mul #(.AW(48), .BW(33)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod)
  );

  logic [47:0] a_abs;
  logic        a_neg;
  logic [32:0] b_abs;
  logic        b_neg;
  logic signed [48:0] a_src;
  logic signed [33:0] b_src;

  always_comb begin
    a_src = '0;
    b_src = '0;
    case (mstep)
      3'd0: begin a_src = 49'(signed'(item.vel_x)); b_src = cosv; end
      3'd1: begin a_src = 49'(signed'(item.vel_y)); b_src = sinv; end
      3'd2: begin a_src = 49'(signed'(item.vel_x)); b_src = sinv; end
      3'd3: begin a_src = 49'(signed'(item.vel_y)); b_src = cosv; end
      3'd4: begin a_src = 49'(dxp); b_src = 34'(item.step_us); end
      3'd5: begin a_src = 49'(dyp); b_src = 34'(item.step_us); end
      3'd6: begin
        a_src = 49'(item.yaw_rate[15] ? -signed'(item.yaw_rate) : signed'(item.yaw_rate));
        b_src = 34'(item.step_us);
      end
      default: begin a_src = 49'(yaw_mag[47:0]); b_src = 34'(poi_pkg::YAW_SCALE); end
    endcase
    a_neg = a_src[48];
    a_abs = a_neg ? 48'(-a_src) : a_src[47:0];
    b_neg = b_src[33];
    b_abs = b_neg ? 33'(-b_src) : b_src[32:0];
    ma = a_abs;
    mb = b_abs;
  end

  logic sgn_r;
  logic signed [81:0] sprod;
  assign sprod = sgn_r ? -$signed({1'b0, mprod}) : $signed({1'b0, mprod});

  // rounding and saturation
  function automatic logic signed [PW+1:0] rnd(input logic signed [81:0] p);
    logic [81:0] m;
    logic [81:0] r;
    logic signed [PW+1:0] q;
    begin
      m = p[81] ? 82'(-p) : p;
      r = (m + (82'd1 << 29)) >> 30;
      q = (PW + 2)'(r);
      if (r > 82'((82'd1 << PW) - 1)) q = (PW + 2)'(82'd1 << PW);
      return p[81] ? -q : q;
    end
  endfunction

  function automatic logic [PW-1:0] sat(input logic [PW-1:0] pos,
                                         input logic signed [PW+1:0] d);
    logic signed [PW+1:0] s;
    logic signed [PW+1:0] hi, lo;
    begin
      hi = (PW + 2)'((82'd1 << (PW - 1)) - 1);
      lo = -hi - 1;
      s = $signed({{2{pos[PW-1]}}, pos}) + d;
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return s[PW-1:0];
    end
  endfunction

  logic signed [PW+1:0] dx_r, dy_r;
  logic [PW-1:0] nx, ny;
  logic [ANGLE_WIDTH-1:0] nh;
  logic [63:0] dq;
  localparam int SH = 64 - ANGLE_WIDTH;

  always_comb begin
    dq = 64'((yaw_mag + (81'd1 << (SH - 1))) >> SH);
    if (item.yaw_rate[15]) begin
      dq = -dq;
    end
    nh = heading_angle + dq[ANGLE_WIDTH-1:0];
  end

  assign in_ch.ready = (state == S_IDLE);

  logic [31:0] a32;
  always_comb begin
    a32 = (32'(heading_angle) << (32 - ANGLE_WIDTH)) + 32'h2000_0000;
  end

  always_ff @(posedge clk) begin
    mstart <= 1'b0;
    if (rst) begin
      state         <= S_IDLE;
      x_pos         <= '0;
      y_pos         <= '0;
      heading_angle <= '0;
      out_ch.valid  <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            item <= in_ch.payload;
            if (in_ch.payload.operation == poi_pkg::OP_RESET) begin
              changed       <= (x_pos != '0) || (y_pos != '0) || (heading_angle != '0);
              x_pos         <= '0;
              y_pos         <= '0;
              heading_angle <= '0;
              state         <= S_DONE;
            end else if (in_ch.payload.step_us == 16'd0) begin
              changed <= 1'b0;
              state   <= S_DONE;
            end else begin
              quad  <= a32[31:30];
              cz    <= 34'($signed({1'b0, a32[29:0]})) - 34'sh2000_0000;
              cx    <= 34'(poi_pkg::CORDIC_GAIN);
              cy    <= '0;
              step  <= '0;
              state <= S_CORD;
            end
          end
        end
        S_CORD: begin
          if (step == SW'(CORDIC_STEPS)) begin
            case (quad)
              2'd0: begin cosv <= cx;  sinv <= cy;  end
              2'd1: begin cosv <= -cy; sinv <= cx;  end
              2'd2: begin cosv <= -cx; sinv <= -cy; end
              default: begin cosv <= cy; sinv <= -cx; end
            endcase
            mstep <= 3'd0;
            state <= S_MUL;
          end else begin
            if (!cz[33]) begin
              cx <= cx - (cy >>> step);
              cy <= cy + (cx >>> step);
              cz <= cz - 34'(poi_pkg::atan_entry(5'(step)));
            end else begin
              cx <= cx + (cy >>> step);
              cy <= cy - (cx >>> step);
              cz <= cz + 34'(poi_pkg::atan_entry(5'(step)));
            end
            step <= step + 1'b1;
          end
        end
        S_MUL: begin
          sgn_r  <= a_neg ^ b_neg;
          mstart <= 1'b1;
          state  <= S_WAIT;
        end
        S_WAIT: begin
          if (mdone) begin
            case (mstep)
              3'd0: t_xc <= 64'(sprod);
              3'd1: t_ys <= 64'(sprod);
              3'd2: t_xs <= 64'(sprod);
              3'd3: begin
                dxp <= t_xc - t_ys;
                dyp <= t_xs + 64'(sprod);
              end
              3'd4: dx_r <= rnd(sprod);
              3'd5: dy_r <= rnd(sprod);
              default: yaw_mag <= mprod;
            endcase
            if (mstep == 3'd7) begin
              state <= S_POS;
            end else begin
              mstep <= mstep + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_POS: begin
          nx    <= sat(x_pos, dx_r);
          ny    <= sat(y_pos, dy_r);
          state <= S_YAW;
        end
        S_YAW: begin
          changed       <= (nx != x_pos) || (ny != y_pos) || (nh != heading_angle);
          x_pos         <= nx;
          y_pos         <= ny;
          heading_angle <= nh;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid) begin
            out_ch.valid           <= 1'b1;
            out_ch.payload.pos_x   <= 48'($signed(x_pos));
            out_ch.payload.pos_y   <= 48'($signed(y_pos));
            out_ch.payload.heading <= 32'(heading_angle);
            out_ch.payload.updated <= changed;
            state                  <= S_OUT;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### dv/odometry_checker.sv
`timescale 1ns / 1ps
module odometry_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  poi_pkg::in_item_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  poi_pkg::out_item_t out_data,
  output int   fail_count,
  output int   pending
);
  longint x_nm, y_nm;
  bit [31:0] head_ba;
  poi_pkg::out_item_t pose_q[$];

  localparam longint POS_HI = (64'sd1 <<< 47) - 1;
  localparam longint POS_LO = -POS_HI - 1;

  function automatic longint asr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_q30(longint p);
    longint m, r;
    m = p < 0 ? -p : p;
    r = (m + (64'sd1 <<< 29)) >>> 30;
    return p < 0 ? -r : r;
  endfunction

  function automatic longint sat_add(longint p, longint d);
    if (d > 0 && p > POS_HI - d) return POS_HI;
    if (d < 0 && p < POS_LO - d) return POS_LO;
    return p + d;
  endfunction

  task automatic rotate_heading(input bit [31:0] ang, output longint c, output longint s);
    bit [31:0] sh;
    bit [1:0] quad;
    longint z, x, y, xs, ys;
    sh = ang + 32'h2000_0000;
    quad = sh[31:30];
    z = longint'({2'b00, sh[29:0]}) - 64'sd536870912;
    x = 652032874;
    y = 0;
    for (int i = 0; i < poi_pkg::CORDIC_STEPS_DEF; i++) begin
      xs = asr_floor(x, i);
      ys = asr_floor(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(poi_pkg::atan_entry(i[4:0]));
      end else begin
        x += ys; y -= xs; z += longint'(poi_pkg::atan_entry(i[4:0]));
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_pose(input poi_pkg::in_item_t it);
    longint vx, vy, w, dt, c, s, ox, oy;
    bit [31:0] oh;
    bit [63:0] mag, dq;
    poi_pkg::out_item_t r;
    ox = x_nm; oy = y_nm; oh = head_ba;
    if (it.operation == poi_pkg::OP_RESET) begin
      x_nm = 0; y_nm = 0; head_ba = 0;
    end else if (it.step_us != 0) begin
      vx = longint'($signed(it.vel_x));
      vy = longint'($signed(it.vel_y));
      w  = longint'($signed(it.yaw_rate));
      dt = longint'(it.step_us);
      rotate_heading(head_ba, c, s);
      x_nm = sat_add(x_nm, round_q30((vx * c - vy * s) * dt));
      y_nm = sat_add(y_nm, round_q30((vx * s + vy * c) * dt));
      mag = 64'(w < 0 ? -w : w) * 64'(dt) * 64'd2935890503;
      dq = (mag + (64'd1 << 31)) >> 32;
      if (w < 0) dq = -dq;
      head_ba = head_ba + dq[31:0];
    end
    r.pos_x = x_nm[47:0];
    r.pos_y = y_nm[47:0];
    r.heading = head_ba;
    r.updated = (x_nm != ox || y_nm != oy || head_ba != oh);
    pose_q.push_back(r);
  endtask

  always @(posedge clk) begin
    poi_pkg::out_item_t e;
    if (rst) begin
      x_nm <= 0; y_nm <= 0; head_ba <= 0;
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) predict_pose(in_data);
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $display("%0t unexpected pose transaction %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = pose_q.pop_front();
          if (e !== out_data) begin
            $display("%0t pose mismatch exp x=%h y=%h h=%h u=%b act x=%h y=%h h=%h u=%b",
                     $time, e.pos_x, e.pos_y, e.heading, e.updated,
                     out_data.pos_x, out_data.pos_y, out_data.heading, out_data.updated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = pose_q.size();
endmodule

### dv/tb_planar_odometry_integrator_top.sv
`timescale 1ns / 1ps
module tb_planar_odometry_integrator_top;
  logic clk = 0;
  logic rst = 1;
  int fail_count, pending, idle_cycles;
  bit timed_out = 0;

  poi_stream_if #(.payload_t(poi_pkg::in_item_t))  in_ch();
  poi_stream_if #(.payload_t(poi_pkg::out_item_t)) out_ch();

  planar_odometry_integrator_top i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  odometry_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.payload),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input poi_pkg::in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic poi_pkg::in_item_t make_item(bit op, logic [15:0] vx, logic [15:0] vy,
                                                  logic [15:0] w, logic [15:0] dt);
    poi_pkg::in_item_t it;
    it.operation = op; it.vel_x = vx; it.vel_y = vy; it.yaw_rate = w; it.step_us = dt;
    return it;
  endfunction

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else if ($urandom_range(0, 99) < 3) out_ch.ready <= 0;
    else if (!out_ch.ready && $urandom_range(0, 99) < 35) out_ch.ready <= 1;
    else if ($urandom_range(0, 99) < 8) out_ch.ready <= ~out_ch.ready;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1;
      $display("FAIL planar_odometry_integrator_top");
      $finish;
    end
  end

  initial begin
    poi_pkg::in_item_t it;
    in_ch.valid = 0;
    in_ch.payload = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_item(make_item(poi_pkg::OP_RESET, 16'h0, 16'h0, 16'h0, 16'h0));
    send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h7fff, 16'h0000, 16'h7fff, 16'hffff));
    send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h8000, 16'h8000, 16'h8000, 16'hffff));
    send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h1234, 16'h7fff, 16'h4000, 16'h0000));
    send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h7fff, 16'h8000, 16'h0000, 16'h0001));
    send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h0000, 16'h0000, 16'h0000, 16'hffff));
    send_item(make_item(poi_pkg::OP_RESET, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_item(make_item(poi_pkg::OP_RESET, 16'h0, 16'h0, 16'h0, 16'h0));
    for (int q = 0; q < 8; q++)
      send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h0, 16'h0, 16'h7fff,
                          16'(3000 + q * 77)));
    for (int q = 0; q < 6; q++)
      send_item(make_item(poi_pkg::OP_INTEGRATE, 16'h7fff, 16'h7fff, 16'h0, 16'hffff));
    // random mix with occasional pose resets
    for (int q = 0; q < 3000; q++) begin
      if (q % 1000 == 0)
        send_item(make_item(poi_pkg::OP_RESET, 16'h0, 16'h0, 16'h0, 16'h0));
      it = make_item(poi_pkg::OP_INTEGRATE, pick16(), pick16(), pick16(), pick16());
      if ($urandom_range(0, 99) < 4) it.operation = poi_pkg::OP_RESET;
      if (q >= 1200) break;
      send_item(it);
    end
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("PASS planar_odometry_integrator_top");
    else $display("FAIL planar_odometry_integrator_top");
    $finish;
  end
endmodule

### filelist.f
design/poi_pkg.sv
design/poi_stream_if.sv
design/poi_serial_mul.sv
design/planar_odometry_integrator_top.sv
dv/odometry_checker.sv
dv/tb_planar_odometry_integrator_top.sv
